// ----- rtl/core/bpdd_pkg.sv -----
// ============================================================================
// bpdd_pkg
// Shared types and codes for the base presence debounce detector.
// ============================================================================
`default_nettype none

package bpdd_pkg;

    // Event codes carried in the func field
    typedef enum logic [2:0] {
        FUNC_TICK         = 3'd0,
        FUNC_EDGE         = 3'd1,
        FUNC_ADC_RESULT   = 3'd2,
        FUNC_ENABLE       = 3'd3,
        FUNC_DISABLE      = 3'd4,
        FUNC_FORCE_ATTACH = 3'd5,
        FUNC_FORCE_DETACH = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_UNKNOWN      = 2'd0,
        ST_DISCONNECTED = 2'd1,
        ST_CONNECTED    = 2'd2
    } status_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ATTACH_DEBOUNCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DETACH_DEBOUNCE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY           = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACH_MAX_MV   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DETACH_MIN_MV   = 3'd4;

    localparam int unsigned TICKS_W = 16;
    localparam int unsigned MV_W    = 12;

    localparam logic [TICKS_W-1:0] ATTACH_DEBOUNCE_RST = 16'd350;
    localparam logic [TICKS_W-1:0] DETACH_DEBOUNCE_RST = 16'd20;
    localparam logic [TICKS_W-1:0] RETRY_RST           = 16'd500;
    localparam logic [MV_W-1:0]    ATTACH_MAX_MV_RST   = 12'd400;
    localparam logic [MV_W-1:0]    DETACH_MIN_MV_RST   = 12'd2900;

    typedef struct packed {
        logic [TICKS_W-1:0] attach_debounce_ticks;
        logic [TICKS_W-1:0] detach_debounce_ticks;
        logic [TICKS_W-1:0] retry_ticks;
        logic [MV_W-1:0]    attach_max_mv;
        logic [MV_W-1:0]    detach_min_mv;
    } cfg_t;

    typedef struct packed {
        logic [2:0]      func;
        logic [MV_W-1:0] adc_mv;
        logic            presence_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] dock_status;
        logic       base_attached;
        logic       tablet_request;
        logic       status_changed;
        logic       adc_request;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpdd_cfg_regs.sv -----
// ============================================================================
// bpdd_cfg_regs
// Configuration register file; writes beyond the last index are dropped.
// ============================================================================
`default_nettype none

module bpdd_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bpdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bpdd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bpdd_pkg::cfg_t                           cfg
);

    bpdd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attach_debounce_ticks <= bpdd_pkg::ATTACH_DEBOUNCE_RST;
            cfg_reg.detach_debounce_ticks <= bpdd_pkg::DETACH_DEBOUNCE_RST;
            cfg_reg.retry_ticks           <= bpdd_pkg::RETRY_RST;
            cfg_reg.attach_max_mv         <= bpdd_pkg::ATTACH_MAX_MV_RST;
            cfg_reg.detach_min_mv         <= bpdd_pkg::DETACH_MIN_MV_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bpdd_pkg::REG_ATTACH_DEBOUNCE: begin
                    cfg_reg.attach_debounce_ticks <= cfg_data;
                end
                bpdd_pkg::REG_DETACH_DEBOUNCE: begin
                    cfg_reg.detach_debounce_ticks <= cfg_data;
                end
                bpdd_pkg::REG_RETRY: begin
                    cfg_reg.retry_ticks <= cfg_data;
                end
                bpdd_pkg::REG_ATTACH_MAX_MV: begin
                    cfg_reg.attach_max_mv <= cfg_data[bpdd_pkg::MV_W-1:0];
                end
                bpdd_pkg::REG_DETACH_MIN_MV: begin
                    cfg_reg.detach_min_mv <= cfg_data[bpdd_pkg::MV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpdd_detect.sv -----
// ============================================================================
// bpdd_detect
// Detector state and per-event update; result is formed combinationally.
// ============================================================================
`default_nettype none

module bpdd_detect #(
    parameter int unsigned COUNT_WIDTH = 16,
    parameter int unsigned MV_WIDTH    = 12
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire bpdd_pkg::in_item_t  item,
    input  wire bpdd_pkg::cfg_t      cfg,
    output bpdd_pkg::out_item_t      result
);

    // Wide enough for both the tick registers and the countdown
    localparam int unsigned LOAD_W =
        (COUNT_WIDTH > bpdd_pkg::TICKS_W) ? COUNT_WIDTH : bpdd_pkg::TICKS_W;
    localparam logic [LOAD_W-1:0] LOAD_MAX = LOAD_W'({COUNT_WIDTH{1'b1}});

    bpdd_pkg::status_t      status_reg, status_next;
    logic                   enabled_reg, enabled_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   armed_reg, armed_next;
    logic                   awaiting_reg, awaiting_next;
    logic                   adc_req;

    logic [bpdd_pkg::TICKS_W-1:0] debounce_sel;
    logic [LOAD_W-1:0]            debounce_wide, retry_wide;
    logic [COUNT_WIDTH-1:0]       debounce_load, retry_load;
    logic [MV_WIDTH-1:0]          mv, attach_max, detach_min;

    assign debounce_sel  = (status_reg == bpdd_pkg::ST_CONNECTED)
                         ? cfg.detach_debounce_ticks : cfg.attach_debounce_ticks;
    assign debounce_wide = LOAD_W'(debounce_sel);
    assign retry_wide    = LOAD_W'(cfg.retry_ticks);

    // Saturate loads at the countdown width
    assign debounce_load = (debounce_wide > LOAD_MAX) ? COUNT_WIDTH'(LOAD_MAX)
                                                      : COUNT_WIDTH'(debounce_wide);
    assign retry_load    = (retry_wide > LOAD_MAX) ? COUNT_WIDTH'(LOAD_MAX)
                                                   : COUNT_WIDTH'(retry_wide);

    assign mv         = MV_WIDTH'(item.adc_mv);
    assign attach_max = MV_WIDTH'(cfg.attach_max_mv);
    assign detach_min = MV_WIDTH'(cfg.detach_min_mv);

    always_comb begin
        status_next   = status_reg;
        enabled_next  = enabled_reg;
        count_next    = count_reg;
        armed_next    = armed_reg;
        awaiting_next = awaiting_reg;
        adc_req       = 1'b0;

        unique case (item.func)
            bpdd_pkg::FUNC_TICK: begin
                if (armed_reg) begin
                    if (count_reg > COUNT_WIDTH'(1)) begin
                        count_next = count_reg - COUNT_WIDTH'(1);
                    end else begin
                        count_next    = '0;
                        armed_next    = 1'b0;
                        awaiting_next = 1'b1;
                        adc_req       = 1'b1;
                    end
                end
            end
            bpdd_pkg::FUNC_EDGE: begin
                if (enabled_reg && !awaiting_reg) begin
                    count_next = debounce_load;
                    armed_next = 1'b1;
                end
            end
            bpdd_pkg::FUNC_ADC_RESULT: begin
                if (awaiting_reg) begin
                    awaiting_next = 1'b0;
                    // detach test wins when the thresholds overlap
                    if (mv >= detach_min) begin
                        status_next = bpdd_pkg::ST_DISCONNECTED;
                    end else if (mv <= attach_max) begin
                        status_next = bpdd_pkg::ST_CONNECTED;
                    end else begin
                        count_next = retry_load;
                        armed_next = 1'b1;
                    end
                end
            end
            bpdd_pkg::FUNC_ENABLE: begin
                enabled_next = 1'b1;
                status_next  = item.presence_level ? bpdd_pkg::ST_CONNECTED
                                                   : bpdd_pkg::ST_DISCONNECTED;
            end
            bpdd_pkg::FUNC_DISABLE, bpdd_pkg::FUNC_FORCE_ATTACH,
            bpdd_pkg::FUNC_FORCE_DETACH: begin
                if (item.func == bpdd_pkg::FUNC_FORCE_ATTACH) begin
                    status_next = bpdd_pkg::ST_CONNECTED;
                end else if (item.func == bpdd_pkg::FUNC_FORCE_DETACH) begin
                    status_next = bpdd_pkg::ST_DISCONNECTED;
                end
                enabled_next  = 1'b0;
                armed_next    = 1'b0;
                count_next    = '0;
                awaiting_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.dock_status    = status_next;
        result.base_attached  = (status_next == bpdd_pkg::ST_CONNECTED);
        result.tablet_request = (status_next == bpdd_pkg::ST_DISCONNECTED);
        result.status_changed = (status_next != status_reg);
        result.adc_request    = adc_req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg   <= bpdd_pkg::ST_UNKNOWN;
            enabled_reg  <= 1'b0;
            count_reg    <= '0;
            armed_reg    <= 1'b0;
            awaiting_reg <= 1'b0;
        end else if (accept) begin
            status_reg   <= status_next;
            enabled_reg  <= enabled_next;
            count_reg    <= count_next;
            armed_reg    <= armed_next;
            awaiting_reg <= awaiting_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpdd_out_skid.sv -----
// ============================================================================
// bpdd_out_skid
// Result register with one skid entry so input ready is fully registered.
// ============================================================================
`default_nettype none

module bpdd_out_skid (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire bpdd_pkg::out_item_t  result,
    output logic                      in_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bpdd_pkg::out_item_t       m_data
);

    logic                out_valid_reg;
    bpdd_pkg::out_item_t out_data_reg;
    logic                skid_valid_reg;
    bpdd_pkg::out_item_t skid_data_reg;

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            // output slot frees: drain the skid first, else take the new beat
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (accept) begin
                out_data_reg <= result;
            end
        end else if (accept) begin
            skid_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/base_presence_debounce_detect_unit.sv -----
// ============================================================================
// base_presence_debounce_detect_unit
// Keyboard base presence detector: debounced edges, ADC window comparison.
// ============================================================================
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  event   | s_valid, s_ready, s_data (in_item_t)   | in
//  result  | m_valid, m_ready, m_data (out_item_t)  | out
//  config  | cfg_valid, cfg_ready, cfg_index, data  | in
//
//  One event is accepted per cycle while s_ready is high; its result is
//  registered into the output slot, or into the skid entry when that slot
//  is full and m_ready is low. The detector state updates on the accepting
//  edge. One skid entry holds a result while m_ready is low; s_ready drops
//  only once both result slots are full. Synchronous active-low reset clears
//  state, outputs and loads config defaults. cfg_ready is always high.
// ============================================================================
`default_nettype none

module base_presence_debounce_detect_unit #(
    parameter int unsigned COUNT_WIDTH = 16,
    parameter int unsigned MV_WIDTH    = 12
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire bpdd_pkg::in_item_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output bpdd_pkg::out_item_t                   m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpdd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bpdd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bpdd_pkg::cfg_t      cfg;
    bpdd_pkg::out_item_t result;
    logic                accept;

    assign accept = s_valid && s_ready;

    bpdd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpdd_detect #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MV_WIDTH    (MV_WIDTH)
    ) u_detect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .cfg     (cfg),
        .result  (result)
    );

    bpdd_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .result   (result),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
